// File: rtl/core/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the acoustic phasor field point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package afp_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic REG_WAVE_NUMBER    = 1'b0;
  localparam logic REG_ACTIVE_SOURCES = 1'b1;

  localparam logic [31:0] WAVE_NUMBER_RESET    = 32'd48913166;
  localparam logic [6:0]  ACTIVE_SOURCES_RESET = 7'd1;

  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0] LEVEL_MAX = 32'hFFFF_FFFF;

  typedef enum logic [5:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_SQX, ST_SQY, ST_SQZ, ST_SUM, ST_ROOT, ST_WAIT,
    ST_PHASE, ST_INDEX, ST_QS_SQ, ST_QS_X2, ST_QS_M9, ST_QS_P7, ST_QS_M7,
    ST_QS_P5, ST_QS_M5, ST_QS_P3, ST_QS_M3, ST_QS_P1, ST_QS_MX, ST_QS_END,
    ST_MUL_C, ST_MUL_S, ST_ACC, ST_LV_ABS, ST_LV_SQA, ST_LV_SQB, ST_LV_SUM,
    ST_LV_ROOT, ST_LV_WAIT, ST_DONE
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_START, OP_READ, OP_DIFF, OP_SQX, OP_SQY, OP_SQZ,
    OP_SUM, OP_ROOT, OP_PHASE, OP_INDEX, OP_QS_SQ, OP_QS_X2, OP_QS_M9,
    OP_QS_P7, OP_QS_M7, OP_QS_P5, OP_QS_M5, OP_QS_P3, OP_QS_M3, OP_QS_P1,
    OP_QS_MX, OP_QS_END, OP_MUL_C, OP_MUL_S, OP_ACC, OP_LV_ABS, OP_LV_SQA,
    OP_LV_SQB, OP_LV_SUM, OP_LV_ROOT, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_b;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_src;
    logic no_src;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/afp_ctrl.sv
// ----------------------------------------------------------------------------
// afp_ctrl
// Sequencer that steps the datapath through each source and the level stage.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_ctrl import afp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_req_type,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.sel_b     = pass_r;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_req_type == REQ_EVAL) begin
            cmd.op    = OP_START;
            state_nxt = stat.no_src ? ST_LV_ABS : ST_READ;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      ST_READ:  begin cmd.op = OP_READ;  state_nxt = ST_DIFF;  end
      ST_DIFF:  begin cmd.op = OP_DIFF;  state_nxt = ST_SQX;   end
      ST_SQX:   begin cmd.op = OP_SQX;   state_nxt = ST_SQY;   end
      ST_SQY:   begin cmd.op = OP_SQY;   state_nxt = ST_SQZ;   end
      ST_SQZ:   begin cmd.op = OP_SQZ;   state_nxt = ST_SUM;   end
      ST_SUM:   begin cmd.op = OP_SUM;   state_nxt = ST_ROOT;  end
      ST_ROOT:  begin cmd.op = OP_ROOT;  state_nxt = ST_WAIT;  end
      ST_WAIT: begin
        if (!stat.busy) begin
          state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: begin cmd.op = OP_PHASE; state_nxt = ST_INDEX; end
      ST_INDEX: begin
        cmd.op    = OP_INDEX;
        pass_nxt  = 1'b0;
        state_nxt = ST_QS_SQ;
      end
      ST_QS_SQ: begin cmd.op = OP_QS_SQ; state_nxt = ST_QS_X2; end
      ST_QS_X2: begin cmd.op = OP_QS_X2; state_nxt = ST_QS_M9; end
      ST_QS_M9: begin cmd.op = OP_QS_M9; state_nxt = ST_QS_P7; end
      ST_QS_P7: begin cmd.op = OP_QS_P7; state_nxt = ST_QS_M7; end
      ST_QS_M7: begin cmd.op = OP_QS_M7; state_nxt = ST_QS_P5; end
      ST_QS_P5: begin cmd.op = OP_QS_P5; state_nxt = ST_QS_M5; end
      ST_QS_M5: begin cmd.op = OP_QS_M5; state_nxt = ST_QS_P3; end
      ST_QS_P3: begin cmd.op = OP_QS_P3; state_nxt = ST_QS_M3; end
      ST_QS_M3: begin cmd.op = OP_QS_M3; state_nxt = ST_QS_P1; end
      ST_QS_P1: begin cmd.op = OP_QS_P1; state_nxt = ST_QS_MX; end
      ST_QS_MX: begin cmd.op = OP_QS_MX; state_nxt = ST_QS_END; end
      ST_QS_END: begin
        cmd.op = OP_QS_END;
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_QS_SQ;
        end else begin
          state_nxt = ST_MUL_C;
        end
      end
      ST_MUL_C: begin cmd.op = OP_MUL_C; state_nxt = ST_MUL_S; end
      ST_MUL_S: begin cmd.op = OP_MUL_S; state_nxt = ST_ACC;   end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = stat.last_src ? ST_LV_ABS : ST_READ;
      end
      ST_LV_ABS:  begin cmd.op = OP_LV_ABS;  state_nxt = ST_LV_SQA;  end
      ST_LV_SQA:  begin cmd.op = OP_LV_SQA;  state_nxt = ST_LV_SQB;  end
      ST_LV_SQB:  begin cmd.op = OP_LV_SQB;  state_nxt = ST_LV_SUM;  end
      ST_LV_SUM:  begin cmd.op = OP_LV_SUM;  state_nxt = ST_LV_ROOT; end
      ST_LV_ROOT: begin cmd.op = OP_LV_ROOT; state_nxt = ST_LV_WAIT; end
      ST_LV_WAIT: begin
        if (!stat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/afp_datapath.sv
// ----------------------------------------------------------------------------
// afp_datapath
// Source table, shared multiplier, square root and divider units, phasor
// accumulators and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_datapath import afp_pkg::*; #(
  parameter int MAX_SOURCES      = 64,
  parameter int PHASE_TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [5:0]         in_source_index,
  input  wire logic signed [23:0] in_coord_x,
  input  wire logic signed [23:0] in_coord_y,
  input  wire logic signed [23:0] in_coord_z,
  input  wire logic [31:0]        wave_number,
  input  wire logic [6:0]         active_sources,
  output logic [31:0]             out_rms_level,
  output logic                    out_saturated
);

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam int P  = PHASE_TABLE_BITS;

  logic [71:0] mem [0:MAX_SOURCES-1];
  logic [71:0] rd_r;

  logic signed [23:0] lx_r, ly_r, lz_r;
  logic [24:0]        ux_r, uy_r, uz_r;
  logic [49:0]        dsq_r;
  logic [63:0]        prod_r;
  logic [31:0]        mul_a, mul_b;
  logic [CW-1:0]      cnt_r, n_r, n_cfg;
  logic [31:0]        n32, wa32;
  logic               amp_sat_r, sat_r, lv_sat_r;
  logic [31:0]        amp_w;
  logic [1:0]         q_r;
  logic [30:0]        xa_r, xb_r, arg, x2_r, p_r, sa_r, sb_r;
  logic [30:0]        cmag, smag;
  logic               cneg, sneg;
  logic [32:0]        ct_r, rnd_term;
  logic [63:0]        rnd;
  logic signed [47:0] re_r, im_r;
  logic [47:0]        abs_re, abs_im;
  logic [31:0]        a1_r, b1_r;
  logic               a0_r, b0_r, ovf_r;
  logic [65:0]        k_r;
  logic [40:0]        ph_sum;
  logic [P-1:0]       ph_idx;
  logic [24:0]        dx, dy, dz;
  logic [30:0]        hsub;

  logic [63:0] sq_v_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [5:0]  sq_cnt_r;
  logic        sq_busy_r;
  logic [35:0] sq_t, sq_trial;

  logic [49:0] dv_rem_r;
  logic [31:0] dv_q_r;
  logic [5:0]  dv_cnt_r;
  logic        dv_busy_r;
  logic [50:0] dv_r2;
  logic        dv_ge;

  assign n32   = ({25'd0, active_sources} > 32'(MAX_SOURCES)) ?
                 32'(MAX_SOURCES) : {25'd0, active_sources};
  assign n_cfg = n32[CW-1:0];
  assign wa32  = {26'd0, in_source_index};

  assign stat.busy     = sq_busy_r || dv_busy_r;
  assign stat.last_src = (({1'b0, cnt_r} + 1'b1) == {1'b0, n_r});
  assign stat.no_src   = (n_cfg == '0);

  assign arg   = cmd.sel_b ? xb_r : xa_r;
  assign amp_w = amp_sat_r ? LEVEL_MAX : dv_q_r;
  assign cmag  = q_r[0] ? sa_r : sb_r;
  assign smag  = q_r[0] ? sb_r : sa_r;
  assign cneg  = q_r[1] ^ q_r[0];
  assign sneg  = q_r[1];

  assign rnd      = prod_r + 64'h2000_0000;
  assign rnd_term = rnd[62:30];
  assign hsub     = prod_r[60:30];

  assign dx = {lx_r[23], lx_r} - {rd_r[71], rd_r[71:48]};
  assign dy = {ly_r[23], ly_r} - {rd_r[47], rd_r[47:24]};
  assign dz = {lz_r[23], lz_r} - {rd_r[23], rd_r[23:0]};

  assign ph_sum = {1'b0, prod_r[39:0]} + (41'd1 << (39 - P));
  assign ph_idx = ph_sum[39:40-P];

  assign abs_re = re_r[47] ? 48'(-re_r) : 48'(re_r);
  assign abs_im = im_r[47] ? 48'(-im_r) : 48'(im_r);

  assign sq_t     = {sq_rem_r, sq_v_r[63:62]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};

  assign dv_r2 = {dv_rem_r, (dv_cnt_r == 6'd49)};
  assign dv_ge = (dv_r2 >= {1'b0, dsq_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQX:    begin mul_a = {7'd0, ux_r}; mul_b = {7'd0, ux_r}; end
      OP_SQY:    begin mul_a = {7'd0, uy_r}; mul_b = {7'd0, uy_r}; end
      OP_SQZ:    begin mul_a = {7'd0, uz_r}; mul_b = {7'd0, uz_r}; end
      OP_PHASE:  begin mul_a = {7'd0, sq_root_r[24:0]}; mul_b = wave_number; end
      OP_QS_SQ:  begin mul_a = {1'b0, arg};  mul_b = {1'b0, arg};  end
      OP_QS_M9:  begin mul_a = {1'b0, x2_r}; mul_b = {1'b0, C9};   end
      OP_QS_M7,
      OP_QS_M5,
      OP_QS_M3:  begin mul_a = {1'b0, x2_r}; mul_b = {1'b0, p_r};  end
      OP_QS_MX:  begin mul_a = {1'b0, arg};  mul_b = {1'b0, p_r};  end
      OP_MUL_C:  begin mul_a = amp_w;        mul_b = {1'b0, cmag}; end
      OP_MUL_S:  begin mul_a = amp_w;        mul_b = {1'b0, smag}; end
      OP_LV_SQA: begin mul_a = a1_r;         mul_b = a1_r;         end
      OP_LV_SQB: begin mul_a = b1_r;         mul_b = b1_r;         end
      default:   begin mul_a = '0;           mul_b = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && wa32 < 32'(MAX_SOURCES)) begin
      mem[wa32[AW-1:0]] <= {in_coord_x, in_coord_y, in_coord_z};
    end
    if (cmd.op == OP_READ) begin
      rd_r <= mem[cnt_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_START: begin
        lx_r <= in_coord_x;
        ly_r <= in_coord_y;
        lz_r <= in_coord_z;
        re_r <= '0;
        im_r <= '0;
      end
      OP_DIFF: begin
        ux_r <= dx[24] ? 25'(-dx) : dx;
        uy_r <= dy[24] ? 25'(-dy) : dy;
        uz_r <= dz[24] ? 25'(-dz) : dz;
      end
      OP_SQY:   dsq_r <= prod_r[49:0];
      OP_SQZ:   dsq_r <= dsq_r + prod_r[49:0];
      OP_SUM:   dsq_r <= dsq_r + prod_r[49:0];
      OP_ROOT:  amp_sat_r <= (dsq_r <= 50'd65536);
      OP_INDEX: begin
        q_r  <= ph_idx[P-1:P-2];
        xa_r <= {1'b0, ph_idx[P-3:0], {(32 - P){1'b0}}};
        xb_r <= ONE_Q30 - {1'b0, ph_idx[P-3:0], {(32 - P){1'b0}}};
      end
      OP_QS_X2: x2_r <= hsub;
      OP_QS_P7: p_r  <= C7 - hsub;
      OP_QS_P5: p_r  <= C5 - hsub;
      OP_QS_P3: p_r  <= C3 - hsub;
      OP_QS_P1: p_r  <= C1 - hsub;
      OP_QS_END: begin
        if (cmd.sel_b) begin
          sb_r <= (hsub > ONE_Q30) ? ONE_Q30 : hsub;
        end else begin
          sa_r <= (hsub > ONE_Q30) ? ONE_Q30 : hsub;
        end
      end
      OP_MUL_S: ct_r <= rnd_term;
      OP_ACC: begin
        re_r <= cneg ? re_r - $signed({15'd0, ct_r}) : re_r + $signed({15'd0, ct_r});
        im_r <= sneg ? im_r - $signed({15'd0, rnd_term}) :
                       im_r + $signed({15'd0, rnd_term});
      end
      OP_LV_ABS: begin
        ovf_r <= (abs_re[47:33] != '0) || (abs_im[47:33] != '0);
        a1_r  <= abs_re[32:1];
        a0_r  <= abs_re[0];
        b1_r  <= abs_im[32:1];
        b0_r  <= abs_im[0];
      end
      OP_LV_SQB: k_r <= {2'b00, prod_r};
      OP_LV_SUM: k_r <= k_r + {2'b00, prod_r} + {34'd0, a0_r ? a1_r : 32'd0}
                        + {34'd0, b0_r ? b1_r : 32'd0};
      OP_OUT: begin
        out_rms_level <= lv_sat_r ? LEVEL_MAX : sq_root_r;
        out_saturated <= sat_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      n_r      <= '0;
      sat_r    <= 1'b0;
      lv_sat_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_START: begin
          cnt_r    <= '0;
          n_r      <= n_cfg;
          sat_r    <= 1'b0;
          lv_sat_r <= 1'b0;
        end
        OP_ROOT: begin
          if (dsq_r <= 50'd65536) begin
            sat_r <= 1'b1;
          end
        end
        OP_ACC: cnt_r <= cnt_r + 1'b1;
        OP_LV_ROOT: begin
          if (ovf_r || k_r[65:63] != '0) begin
            sat_r    <= 1'b1;
            lv_sat_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else if (cmd.op == OP_ROOT ||
                 (cmd.op == OP_LV_ROOT && !ovf_r && k_r[65:63] == '0)) begin
      sq_busy_r <= 1'b1;
      sq_cnt_r  <= 6'd32;
    end else if (sq_busy_r) begin
      sq_cnt_r  <= sq_cnt_r - 1'b1;
      sq_busy_r <= (sq_cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROOT) begin
      sq_v_r    <= {14'd0, dsq_r};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.op == OP_LV_ROOT) begin
      sq_v_r    <= {k_r[62:0], a0_r & b0_r};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_busy_r) begin
      sq_v_r <= {sq_v_r[61:0], 2'b00};
      if (sq_t >= sq_trial) begin
        sq_rem_r  <= 34'(sq_t - sq_trial);
        sq_root_r <= {sq_root_r[30:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_t[33:0];
        sq_root_r <= {sq_root_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_cnt_r  <= '0;
    end else if (cmd.op == OP_ROOT) begin
      dv_busy_r <= 1'b1;
      dv_cnt_r  <= 6'd49;
    end else if (dv_busy_r) begin
      dv_cnt_r  <= dv_cnt_r - 1'b1;
      dv_busy_r <= (dv_cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ROOT) begin
      dv_rem_r <= '0;
      dv_q_r   <= '0;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? 50'(dv_r2 - {1'b0, dsq_r}) : dv_r2[49:0];
      dv_q_r   <= {dv_q_r[30:0], dv_ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/acoustic_phasor_field_point_unit.sv
// ----------------------------------------------------------------------------
// acoustic_phasor_field_point_unit
// Point-source phasor field probe: a table of transducer positions and the
// RMS level of the summed field at each listener point.
// ----------------------------------------------------------------------------
// A load item writes one table entry. An evaluate item steps through each
// active source and then the level stage, which is cut short when the level
// saturates: each source passes through one shared 32 by 32 bit multiplier, a
// 49-step restoring divider for the amplitude and a 32-step square root,
// which is reused for the final level.
// One item is processed at a time; a finished result waits in the output
// register while the next item is accepted.
`default_nettype none

module acoustic_phasor_field_point_unit import afp_pkg::*; #(
  parameter int MAX_SOURCES      = 64,
  parameter int PHASE_TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic [5:0]         in_source_index,
  input  wire logic signed [23:0] in_coord_x,
  input  wire logic signed [23:0] in_coord_y,
  input  wire logic signed [23:0] in_coord_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_rms_level,
  output logic                    out_saturated,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic [31:0] wave_r;
  logic [6:0]  active_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r   <= WAVE_NUMBER_RESET;
      active_r <= ACTIVE_SOURCES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[2])
        REG_WAVE_NUMBER:    wave_r   <= cfg_pwdata;
        REG_ACTIVE_SOURCES: active_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WAVE_NUMBER:    cfg_prdata = wave_r;
      REG_ACTIVE_SOURCES: cfg_prdata = {25'd0, active_r};
      default:            cfg_prdata = '0;
    endcase
  end

  afp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  afp_datapath #(
    .MAX_SOURCES      (MAX_SOURCES),
    .PHASE_TABLE_BITS (PHASE_TABLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_source_index (in_source_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .wave_number     (wave_r),
    .active_sources  (active_r),
    .out_rms_level   (out_rms_level),
    .out_saturated   (out_saturated)
  );

endmodule

`default_nettype wire

// File: rtl/core/afp_checker.sv
// ----------------------------------------------------------------------------
// afp_checker
// Port-level checks of the acoustic phasor field point unit.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_checker import afp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_req_type,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_rms_level,
  input wire logic        out_saturated,
  input wire logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("A stalled result was withdrawn.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rms_level) && $stable(out_saturated))
    else $error("A stalled result changed.");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type == REQ_EVAL |=> in_stall)
    else $error("Input accepted while an evaluation was in progress.");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type == REQ_LOAD && !out_valid |=> !out_valid)
    else $error("A load transfer produced a result.");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("Configuration port inserted a wait state.");

endmodule

bind acoustic_phasor_field_point_unit afp_checker u_afp_checker (.*);

`default_nettype wire
